FILE: rtl/ba_pkg.sv
package ba_pkg;

  localparam int unsigned DEF_MAX_ORDER    = 16;
  localparam int unsigned DEF_MAX_REQUESTS = 1024;

  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned SER_W   = 10;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned BYTES_W = 17;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned PO_W    = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    NODE_ABSENT,
    NODE_FREE,
    NODE_SPLIT,
    NODE_TAKEN
  } node_status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_SEL,
    S_A_DESC,
    S_A_SPLR,
    S_A_SPLL,
    S_F_CHK,
    S_M_CHK,
    S_UP_RD,
    S_UP_WR,
    S_FIN
  } ba_state_e;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] request_size;
    logic [SER_W-1:0]  target_serial;
  } in_req_t;

  typedef struct packed {
    logic [SER_W-1:0]   serial_number;
    logic               succeeded;
    logic [ADDR_W-1:0]  base_address;
    logic [BYTES_W-1:0] block_bytes;
    logic [BYTES_W-1:0] free_bytes;
    logic [BYTES_W-1:0] largest_free;
    logic [COUNT_W-1:0] free_block_count;
  } out_rsp_t;

  typedef logic [PO_W-1:0] cfg_word_t;

  // Order of the smallest power of two that holds the size; zero counts as one.
  function automatic logic [PO_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] v;
    logic [PO_W-1:0]   k;
    v = (size == '0) ? '0 : size - 1'b1;
    k = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) begin
        k = PO_W'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

FILE: rtl/ba_stream_if.sv
interface ba_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/buddy_allocator.sv
// Binary buddy allocator over a pool of 2^pool_order bytes.
// in_req carries one request: allocate (round up to a power of two, smallest
// free block, lowest address) or free (by the serial of an earlier allocate).
// out_rsp returns one response per request with the pool summary after it.
// cfg_wr sets pool_order; it rebuilds the pool and keeps the serial counter.
// The tree of nodes lives in a memory with one read port and one write port,
// and every node carries a mask of the free block orders within its subtree.
// An allocate reads the root, descends the tree level by level to the chosen
// block, splits it down by left halves and then updates the masks of its
// ancestors; a free checks the request table, merges with free buddies upward
// and then updates the ancestors' masks; a refused request goes straight to its
// response. Every request then goes back to the idle state.
// One request is in flight at a time; in_req.ready is high only while idle.
// After reset and after every cfg_wr write, a clearing pass empties every entry
// of the request table; no request is taken during it.
// A finished response sits in an output register; if out_rsp is stalled the
// next request may still be taken and waits only at its own completion.
module buddy_allocator #(
  parameter int unsigned MAX_ORDER    = ba_pkg::DEF_MAX_ORDER,
  parameter int unsigned MAX_REQUESTS = ba_pkg::DEF_MAX_REQUESTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ba_stream_if.sink   in_req,
  ba_stream_if.source out_rsp,
  ba_stream_if.sink   cfg_wr
);

  localparam int unsigned NW   = MAX_ORDER + 1;
  localparam int unsigned MW   = MAX_ORDER + 1;
  localparam int unsigned IW   = $clog2(MAX_REQUESTS);
  localparam int unsigned EW   = 1 + ba_pkg::PO_W + NW;
  localparam int unsigned FB_W = MAX_ORDER + 1;
  localparam int unsigned FC_W = MAX_ORDER;
  localparam int unsigned PW   = ba_pkg::PO_W;
  localparam logic [NW-1:0] ROOT = NW'(1);

  function automatic logic [MW-1:0] low_bits(input logic [PW-1:0] x);
    logic [MW:0] t;
    t = ({{MW{1'b0}}, 1'b1} << x) - 1'b1;
    return t[MW-1:0];
  endfunction

  function automatic logic [MW-1:0] bit_at(input logic [PW-1:0] x);
    return {{(MW-1){1'b0}}, 1'b1} << x;
  endfunction

  function automatic logic [PW-1:0] lowest_set(input logic [MW-1:0] m);
    logic [PW-1:0] r;
    r = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = PW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [PW-1:0] highest_set(input logic [MW-1:0] m);
    logic [PW-1:0] r;
    r = '0;
    for (int i = 0; i < MW; i++) begin
      if (m[i]) begin
        r = PW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [NW-1:0] left_of(input logic [NW-1:0] n);
    return {n[NW-2:0], 1'b0};
  endfunction

  // Memories
  logic [MW+1:0] node_mem [2**NW];
  logic [EW-1:0] tbl_mem [MAX_REQUESTS];

  logic          node_we, node_re;
  logic [NW-1:0] node_wa, node_ra;
  logic [MW+1:0] node_wd, node_rd_q;
  logic          tbl_we, tbl_re;
  logic [IW-1:0] tbl_wa, tbl_ra;
  logic [EW-1:0] tbl_wd, tbl_rd_q;

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      tbl_rd_q <= tbl_mem[tbl_ra];
    end
  end

  ba_pkg::node_status_e rd_st;
  logic [MW-1:0]        rd_mask;
  logic                 ent_valid;
  logic [PW-1:0]        ent_order;
  logic [NW-1:0]        ent_node;

  assign rd_st     = ba_pkg::node_status_e'(node_rd_q[MW+1:MW]);
  assign rd_mask   = node_rd_q[MW-1:0];
  assign ent_valid = tbl_rd_q[EW-1];
  assign ent_order = tbl_rd_q[EW-2 -: PW];
  assign ent_node  = tbl_rd_q[NW-1:0];

  // Registers
  ba_pkg::ba_state_e state_q, state_d;
  logic [PW-1:0]     po_q, po_d;
  logic [IW-1:0]     ser_q, ser_d;
  logic [IW-1:0]     clr_q, clr_d;
  logic              op_q, op_d;
  logic [PW-1:0]     k_q, k_d;
  logic [ba_pkg::SER_W-1:0] t_q, t_d;
  logic [PW-1:0]     o_q, o_d;
  logic [PW-1:0]     j_q, j_d;
  logic [NW-1:0]     n_q, n_d;
  logic [NW-1:0]     f_q, f_d;
  logic [NW-1:0]     upn_q, upn_d;
  logic [MW-1:0]     upm_q, upm_d;
  logic [MW-1:0]     rootm_q, rootm_d;
  logic [MAX_ORDER-1:0] addr_q, addr_d;
  logic              ok_q, ok_d;
  logic [FB_W-1:0]   bytes_q, bytes_d;
  logic [FB_W-1:0]   fbytes_q, fbytes_d;
  logic [FB_W-1:0]   largest_q, largest_d;
  logic [FC_W-1:0]   fcnt_q, fcnt_d;
  logic              out_valid_q, out_valid_d;
  ba_pkg::out_rsp_t  out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ba_pkg::S_INIT;
      po_q        <= PW'(MAX_ORDER);
      ser_q       <= IW'(1);
      clr_q       <= '0;
      fbytes_q    <= FB_W'(1) << MAX_ORDER;
      largest_q   <= FB_W'(1) << MAX_ORDER;
      fcnt_q      <= FC_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      po_q        <= po_d;
      ser_q       <= ser_d;
      clr_q       <= clr_d;
      fbytes_q    <= fbytes_d;
      largest_q   <= largest_d;
      fcnt_q      <= fcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    k_q     <= k_d;
    t_q     <= t_d;
    o_q     <= o_d;
    j_q     <= j_d;
    n_q     <= n_d;
    f_q     <= f_d;
    upn_q   <= upn_d;
    upm_q   <= upm_d;
    rootm_q <= rootm_d;
    addr_q  <= addr_d;
    ok_q    <= ok_d;
    bytes_q <= bytes_d;
    out_q   <= out_d;
  end

  logic [PW-1:0] cfg_po;
  assign cfg_po = (cfg_wr.payload > PW'(MAX_ORDER)) ? PW'(MAX_ORDER) : cfg_wr.payload;

  always_comb begin
    logic          hit;
    logic [NW-1:0] hit_node;
    logic [PW-1:0] hit_o;
    logic [MW-1:0] avail;
    logic [PW-1:0] c;
    logic [NW-1:0] nn;
    logic [NW-1:0] p;
    logic [MW-1:0] pm;
    logic          t_ok;
    logic [FB_W-1:0] fb_new;
    logic [FC_W-1:0] fc_new;
    logic [FB_W-1:0] lg_new;

    state_d = state_q;  po_d = po_q;     ser_d = ser_q;   clr_d = clr_q;
    op_d = op_q;        k_d = k_q;       t_d = t_q;       o_d = o_q;
    j_d = j_q;          n_d = n_q;       f_d = f_q;       upn_d = upn_q;
    upm_d = upm_q;      rootm_d = rootm_q; addr_d = addr_q; ok_d = ok_q;
    bytes_d = bytes_q;  fbytes_d = fbytes_q; largest_d = largest_q; fcnt_d = fcnt_q;
    out_valid_d = out_valid_q & ~out_rsp.ready;
    out_d = out_q;
    node_we = 1'b0; node_wa = '0; node_wd = '0; node_re = 1'b0; node_ra = '0;
    tbl_we = 1'b0;  tbl_wa = '0;  tbl_wd = '0;  tbl_re = 1'b0;  tbl_ra = '0;
    hit = 1'b0; hit_node = '0; hit_o = '0;
    avail = rd_mask & ~low_bits(k_q);
    c = j_q - 1'b1;
    nn = '0; p = '0; pm = '0;
    t_ok = (32'(t_q) < MAX_REQUESTS) && (IW'(t_q) != ser_q);
    fb_new = fbytes_q; fc_new = fcnt_q; lg_new = largest_q;

    case (state_q)
      ba_pkg::S_INIT: begin
        tbl_we  = 1'b1;
        tbl_wa  = clr_q;
        node_we = 1'b1;
        node_wa = ROOT;
        node_wd = {ba_pkg::NODE_FREE, bit_at(po_q)};
        clr_d   = clr_q + 1'b1;
        if (clr_q == IW'(MAX_REQUESTS - 1)) begin
          state_d = ba_pkg::S_IDLE;
        end
      end
      ba_pkg::S_IDLE: begin
        if (in_req.valid) begin
          op_d    = in_req.payload.operation;
          k_d     = ba_pkg::size_order(in_req.payload.request_size);
          t_d     = in_req.payload.target_serial;
          ok_d    = 1'b0;
          addr_d  = '0;
          bytes_d = '0;
          // The item's own slot is released before anything else.
          tbl_we  = 1'b1;
          tbl_wa  = ser_q;
          tbl_wd  = '0;
          if (in_req.payload.operation == ba_pkg::OP_FREE) begin
            tbl_re  = 1'b1;
            tbl_ra  = IW'(in_req.payload.target_serial);
            state_d = ba_pkg::S_F_CHK;
          end else begin
            node_re = 1'b1;
            node_ra = ROOT;
            state_d = ba_pkg::S_A_SEL;
          end
        end
      end
      ba_pkg::S_A_SEL: begin
        if ((k_q > po_q) || (avail == '0)) begin
          state_d = ba_pkg::S_FIN;
        end else begin
          o_d = lowest_set(avail);
          if (lowest_set(avail) == po_q) begin
            hit      = 1'b1;
            hit_node = ROOT;
            hit_o    = po_q;
          end else begin
            n_d     = ROOT;
            j_d     = po_q;
            node_re = 1'b1;
            node_ra = left_of(ROOT);
            state_d = ba_pkg::S_A_DESC;
          end
        end
      end
      ba_pkg::S_A_DESC: begin
        // A split node holding the wanted order has it on the left or else the right.
        if (rd_mask[o_q]) begin
          nn = left_of(n_q);
        end else begin
          nn     = left_of(n_q) | NW'(1);
          addr_d = addr_q | (MAX_ORDER'(1) << c);
        end
        if (c == o_q) begin
          hit      = 1'b1;
          hit_node = nn;
          hit_o    = o_q;
        end else begin
          n_d     = nn;
          j_d     = c;
          node_re = 1'b1;
          node_ra = left_of(nn);
        end
      end
      ba_pkg::S_A_SPLR: begin
        node_we = 1'b1;
        node_wa = left_of(n_q) | NW'(1);
        node_wd = {ba_pkg::NODE_FREE, bit_at(c)};
        state_d = ba_pkg::S_A_SPLL;
      end
      ba_pkg::S_A_SPLL: begin
        node_we = 1'b1;
        node_wa = left_of(n_q);
        n_d     = left_of(n_q);
        if (c > k_q) begin
          node_wd = {ba_pkg::NODE_SPLIT, low_bits(c) & ~low_bits(k_q)};
          j_d     = c;
          state_d = ba_pkg::S_A_SPLR;
        end else begin
          node_wd = {ba_pkg::NODE_TAKEN, {MW{1'b0}}};
          upn_d   = f_q;
          upm_d   = low_bits(o_q) & ~low_bits(k_q);
          state_d = ba_pkg::S_UP_RD;
        end
      end
      ba_pkg::S_F_CHK: begin
        if (t_ok && ent_valid) begin
          tbl_we  = 1'b1;
          tbl_wa  = IW'(t_q);
          tbl_wd  = '0;
          ok_d    = 1'b1;
          bytes_d = FB_W'(1) << ent_order;
          fcnt_d  = fcnt_q + 1'b1;
          n_d     = ent_node;
          j_d     = ent_order;
          if (ent_node == ROOT) begin
            node_we = 1'b1;
            node_wa = ROOT;
            node_wd = {ba_pkg::NODE_FREE, bit_at(ent_order)};
            rootm_d = bit_at(ent_order);
            state_d = ba_pkg::S_FIN;
          end else begin
            node_re = 1'b1;
            node_ra = ent_node ^ NW'(1);
            state_d = ba_pkg::S_M_CHK;
          end
        end else begin
          state_d = ba_pkg::S_FIN;
        end
      end
      ba_pkg::S_M_CHK: begin
        if (rd_st == ba_pkg::NODE_FREE) begin
          p      = n_q >> 1;
          n_d    = p;
          j_d    = j_q + 1'b1;
          fcnt_d = fcnt_q - 1'b1;
          if (p == ROOT) begin
            node_we = 1'b1;
            node_wa = ROOT;
            node_wd = {ba_pkg::NODE_FREE, bit_at(j_q + 1'b1)};
            rootm_d = bit_at(j_q + 1'b1);
            state_d = ba_pkg::S_FIN;
          end else begin
            node_re = 1'b1;
            node_ra = p ^ NW'(1);
          end
        end else begin
          node_we = 1'b1;
          node_wa = n_q;
          node_wd = {ba_pkg::NODE_FREE, bit_at(j_q)};
          upn_d   = n_q;
          upm_d   = bit_at(j_q);
          state_d = ba_pkg::S_UP_RD;
        end
      end
      ba_pkg::S_UP_RD: begin
        if (upn_q == ROOT) begin
          rootm_d = upm_q;
          state_d = ba_pkg::S_FIN;
        end else begin
          node_re = 1'b1;
          node_ra = upn_q ^ NW'(1);
          state_d = ba_pkg::S_UP_WR;
        end
      end
      ba_pkg::S_UP_WR: begin
        // A split parent's mask is the union of its children's masks.
        p       = upn_q >> 1;
        pm      = upm_q | rd_mask;
        node_we = 1'b1;
        node_wa = p;
        node_wd = {ba_pkg::NODE_SPLIT, pm};
        upn_d   = p;
        upm_d   = pm;
        if (p == ROOT) begin
          rootm_d = pm;
          state_d = ba_pkg::S_FIN;
        end else begin
          node_re = 1'b1;
          node_ra = p ^ NW'(1);
        end
      end
      ba_pkg::S_FIN: begin
        if (!out_valid_q || out_rsp.ready) begin
          if (ok_q) begin
            lg_new = (rootm_q == '0) ? '0 : (FB_W'(1) << highest_set(rootm_q));
            if (op_q == ba_pkg::OP_ALLOC) begin
              fb_new = fbytes_q - bytes_q;
              fc_new = fcnt_q + FC_W'(o_q) - FC_W'(k_q) - 1'b1;
              tbl_we = 1'b1;
              tbl_wa = ser_q;
              tbl_wd = {1'b1, k_q, n_q};
            end else begin
              fb_new = fbytes_q + bytes_q;
            end
          end
          fbytes_d  = fb_new;
          fcnt_d    = fc_new;
          largest_d = lg_new;
          out_valid_d = 1'b1;
          out_d.serial_number    = ba_pkg::SER_W'(ser_q);
          out_d.succeeded        = ok_q;
          out_d.base_address     = ba_pkg::ADDR_W'(addr_q);
          out_d.block_bytes      = ba_pkg::BYTES_W'(bytes_q);
          out_d.free_bytes       = ba_pkg::BYTES_W'(fb_new);
          out_d.largest_free     = ba_pkg::BYTES_W'(lg_new);
          out_d.free_block_count = ba_pkg::COUNT_W'(fc_new);
          ser_d   = (ser_q == IW'(MAX_REQUESTS - 1)) ? '0 : ser_q + 1'b1;
          state_d = ba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ba_pkg::S_IDLE;
      end
    endcase

    // The block found is split down by left halves, or taken as it is.
    if (hit) begin
      ok_d    = 1'b1;
      bytes_d = FB_W'(1) << k_q;
      n_d     = hit_node;
      f_d     = hit_node;
      j_d     = hit_o;
      node_we = 1'b1;
      node_wa = hit_node;
      if (hit_o == k_q) begin
        node_wd = {ba_pkg::NODE_TAKEN, {MW{1'b0}}};
        upn_d   = hit_node;
        upm_d   = '0;
        state_d = ba_pkg::S_UP_RD;
      end else begin
        node_wd = {ba_pkg::NODE_SPLIT, low_bits(hit_o) & ~low_bits(k_q)};
        state_d = ba_pkg::S_A_SPLR;
      end
    end

    if (cfg_wr.valid) begin
      po_d      = cfg_po;
      fbytes_d  = FB_W'(1) << cfg_po;
      largest_d = FB_W'(1) << cfg_po;
      fcnt_d    = FC_W'(1);
      clr_d     = '0;
      state_d   = ba_pkg::S_INIT;
    end
  end

  assign in_req.ready    = (state_q == ba_pkg::S_IDLE);
  assign cfg_wr.ready    = 1'b1;
  assign out_rsp.valid   = out_valid_q;
  assign out_rsp.payload = out_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request taken while another is in flight");

  a_largest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    largest_q <= fbytes_q)
    else $error("largest free block exceeds free bytes");

  a_count_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ba_pkg::S_IDLE) |-> ((fcnt_q == '0) == (fbytes_q == '0)))
    else $error("free block count and free bytes disagree");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ba_pkg::S_IDLE) |-> (fbytes_q <= (FB_W'(1) << po_q)))
    else $error("free bytes exceed the pool size");

endmodule
